@@ rtl/msp_pkg.sv @@
// Package with shared constants, types and codes for the servo PWM block.
package msp_pkg;

   localparam int NUM_CHANNELS = 18;

   localparam int CNT_W      = 24;
   localparam int TALLY_W    = 32;
   localparam int CH_IDX_W   = 5;
   localparam int WIDTH_US_W = 16;
   localparam int TPU_W      = 8;
   localparam int KIND_W     = 3;
   localparam int CH_SEL_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   localparam int REQ_DATA_W = ((CH_IDX_W + WIDTH_US_W + 1 + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((NUM_CHANNELS + TALLY_W + 1 + 7) / 8) * 8;

   localparam logic [CNT_W-1:0] PERIOD_TICKS_RST = CNT_W'(420000);
   localparam logic [TPU_W-1:0] TICKS_PER_US_RST = TPU_W'(42);

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_TICKS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_US = CSR_IDX_W'(1);

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK  = 3'd0,
      KIND_WRITE = 3'd1,
      KIND_LOCK  = 3'd2,
      KIND_START = 3'd3,
      KIND_STOP  = 3'd4
   } kind_type;

   // Control from the sequencing logic to the channel bank.
   typedef struct packed {
      logic                wr_en;
      logic [CH_SEL_W-1:0] wr_idx;
      logic [CNT_W-1:0]    wr_val;
      logic                load_en;
      logic [CNT_W-1:0]    count;
   } bank_ctrl_type;

endpackage

@@ rtl/multichannel_servo_pwm.sv @@
// Top level of the multichannel servo PWM generator with shadow compares.
//
//   channel  dir  group                         content
//   req      in   req_tvalid/tready/tdata/tuser one command or tick per item
//   rsp      out  rsp_tvalid/tready/tdata       pin levels, period tally, run flag
//   csr      in   csr_valid/ready/index/data    period_ticks (0), ticks_per_us (1)
//
// Each item is handled in the cycle it is accepted: the state updates at that
// edge and the result lands in the output register, so one item per cycle is
// sustained. The path is set by the 16x8 width multiply on writes and by the
// 24-bit compare of every channel on ticks. Synchronous reset clears all state
// and restores the register defaults. The output register is refilled in the
// cycle it is drained, so a stall on rsp only holds req back while it lasts.
module multichannel_servo_pwm (
   input  logic                               clock,
   input  logic                               reset,
   // channel [4:0], width_us [20:5], lock_on [21], zero fill above
   input  logic [msp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // kind [2:0]
   input  logic [msp_pkg::KIND_W-1:0]         req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pin_levels [17:0], periods_done [49:18], running [50], zero fill above
   output logic [msp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [msp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [msp_pkg::CSR_DATA_W-1:0]     csr_data
);
   import msp_pkg::*;

   localparam int PAD_W = RSP_DATA_W - NUM_CHANNELS - TALLY_W - 1;

   // Configuration registers.
   logic [CNT_W-1:0] period_ticks_ff;
   logic [TPU_W-1:0] ticks_per_us_ff;

   // Timer state.
   logic [CNT_W-1:0]        sync_ff,   sync_in;
   logic [CNT_W-1:0]        chan_ff,   chan_in;
   logic                    active_ff, active_in;
   logic [TALLY_W-1:0]      tally_ff,  tally_in;
   logic [NUM_CHANNELS-1:0] pins_ff,   pins_in;
   logic                    lock_ff,   lock_in;
   logic                    run_ff,    run_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,  rsp_data_in;

   logic                    accept;
   kind_type                kind;
   logic [CH_IDX_W-1:0]     channel;
   logic [WIDTH_US_W-1:0]   width_us;
   logic                    lock_on;
   logic [CNT_W-1:0]        sync_next;
   logic                    period_end;
   logic [CNT_W-1:0]        width_ticks;
   logic [NUM_CHANNELS-1:0] match;
   bank_ctrl_type           bank_ctrl;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign kind     = kind_type'(req_tuser);
   assign channel  = req_tdata[CH_IDX_W-1:0];
   assign width_us = req_tdata[CH_IDX_W +: WIDTH_US_W];
   assign lock_on  = req_tdata[CH_IDX_W + WIDTH_US_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ticks_ff <= PERIOD_TICKS_RST;
         ticks_per_us_ff <= TICKS_PER_US_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PERIOD_TICKS: period_ticks_ff <= csr_data[CNT_W-1:0];
            CSR_TICKS_PER_US: ticks_per_us_ff <= csr_data[TPU_W-1:0];
            default: ;
         endcase
      end
   end

   // A period ends when the counter reaches or passes period_ticks or wraps to zero.
   assign sync_next   = sync_ff + CNT_W'(1);
   assign period_end  = (sync_next >= period_ticks_ff) || (sync_next == '0);
   assign width_ticks = CNT_W'(width_us) * CNT_W'(ticks_per_us_ff);

   always_comb begin
      sync_in   = sync_ff;
      chan_in   = chan_ff;
      active_in = active_ff;
      tally_in  = tally_ff;
      pins_in   = pins_ff;
      lock_in   = lock_ff;
      run_in    = run_ff;

      bank_ctrl.wr_en   = 1'b0;
      bank_ctrl.wr_idx  = channel[CH_SEL_W-1:0];
      bank_ctrl.wr_val  = width_ticks;
      bank_ctrl.load_en = 1'b0;

      if (accept) begin
         case (kind)
            KIND_TICK: begin
               if (run_ff) begin
                  if (period_end) begin
                     sync_in           = '0;
                     pins_in           = '1;
                     bank_ctrl.load_en = !lock_ff;
                     chan_in           = '0;
                     active_in         = 1'b1;
                     tally_in          = tally_ff + TALLY_W'(1);
                  end else begin
                     sync_in = sync_next;
                     if (active_ff) begin
                        chan_in = chan_ff + CNT_W'(1);
                     end
                  end
               end
            end
            KIND_WRITE: begin
               // Writes to channels beyond the bank are dropped.
               bank_ctrl.wr_en = ({1'b0, channel} < (CH_IDX_W + 1)'(NUM_CHANNELS));
            end
            KIND_LOCK: begin
               lock_in = lock_on;
            end
            KIND_START: begin
               run_in  = 1'b1;
               lock_in = 1'b0;
               sync_in = '0;
            end
            KIND_STOP: begin
               run_in    = 1'b0;
               active_in = 1'b0;
            end
            default: ;
         endcase
      end

      bank_ctrl.count = chan_in;

      // Pins fall when the running channel count meets their compare.
      if (accept && (kind == KIND_TICK) && run_ff && active_in) begin
         pins_in = pins_in & ~match;
      end
   end

   msp_chan_bank u_bank (
      .clock (clock),
      .reset (reset),
      .ctrl  (bank_ctrl),
      .match (match)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {PAD_W'(0), run_in, tally_in, pins_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff      <= '0;
         chan_ff      <= '0;
         active_ff    <= 1'b0;
         tally_ff     <= '0;
         pins_ff      <= '1;
         lock_ff      <= 1'b0;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sync_ff      <= sync_in;
         chan_ff      <= chan_in;
         active_ff    <= active_in;
         tally_ff     <= tally_in;
         pins_ff      <= pins_in;
         lock_ff      <= lock_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/msp_chan_bank.sv @@
// Shadow and active compare registers of all channels, with the compare match.
module msp_chan_bank (
   input  logic                                 clock,
   input  logic                                 reset,
   input  msp_pkg::bank_ctrl_type               ctrl,
   output logic [msp_pkg::NUM_CHANNELS-1:0]     match
);
   import msp_pkg::*;

   logic [CNT_W-1:0] shadow_ff [NUM_CHANNELS];
   logic [CNT_W-1:0] active_ff [NUM_CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            shadow_ff[i] <= '0;
            active_ff[i] <= '0;
         end
      end else begin
         if (ctrl.wr_en) begin
            shadow_ff[ctrl.wr_idx] <= ctrl.wr_val;
         end
         if (ctrl.load_en) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               active_ff[i] <= shadow_ff[i];
            end
         end
      end
   end

   // Compare against the values the active set holds after this item.
   always_comb begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         match[i] = ((ctrl.load_en ? shadow_ff[i] : active_ff[i]) == ctrl.count);
      end
   end

endmodule

@@ rtl/msp_checker.sv @@
// Port-level checker for the servo PWM block, bound to the top level.
module msp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic [msp_pkg::KIND_W-1:0]         req_tuser,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [msp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready
);
   import msp_pkg::*;

   localparam int RUN_BIT = NUM_CHANNELS + TALLY_W;

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // With the output register empty the block always takes an item.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // A stop shows up as a stopped timer in the very next result.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == KIND_STOP)
      |=> rsp_tvalid && !rsp_tdata[RUN_BIT])
      else $error("stop not reflected");

   // A start shows up as a running timer in the very next result.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == KIND_START)
      |=> rsp_tvalid && rsp_tdata[RUN_BIT])
      else $error("start not reflected");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind multichannel_servo_pwm msp_checker u_msp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tuser  (req_tuser),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
